### rtl/lcb_pkg.sv
// shared types, constants and the bit-plane byte function of the led cube scan driver
// no dependencies: every other file of the block imports this package
package lcb_pkg;

  localparam int CUBE_SIDE  = 8;
  localparam int COLOR_BITS = 8;
  localparam int PIX_W      = 24;
  localparam int COORD_W    = $clog2(CUBE_SIDE);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int DEPTH      = CUBE_SIDE * CUBE_SIDE;
  localparam int PLANE_W    = 3;
  localparam int TICK_W     = 8;
  localparam int CHAN_W     = 2;
  localparam int BITSEL_W   = CHAN_W + PLANE_W;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // colour channel codes, also the upper part of the bit index in a pixel
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;

  typedef logic [CUBE_SIDE-1:0][PIX_W-1:0] row_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [PIX_W-1:0]   pixel_color;
  } in_beat_t;

  typedef struct packed {
    logic [CUBE_SIDE-1:0] shift_byte;
    logic                 latch_now;
    logic [PLANE_W-1:0]   plane_shown;
  } out_beat_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    row_t              wr_data;
  } store_req_t;

  // one bit of one channel from each pixel of a row, pixel x into bit x
  function automatic logic [CUBE_SIDE-1:0] plane_byte(input row_t row,
                                                      input logic [CHAN_W-1:0] chan,
                                                      input logic [PLANE_W-1:0] plane);
    logic [BITSEL_W-1:0]  bit_sel;
    logic [CUBE_SIDE-1:0] b;
    bit_sel = {chan, plane};
    for (int x = 0; x < CUBE_SIDE; x++) begin
      b[x] = row[x][bit_sel];
    end
    return b;
  endfunction

endpackage

### rtl/lcb_frame_store.sv
// frame store: one row of eight pixels per entry, registered read, one port
// depends on lcb_pkg; entries never written read as zero through per-entry valid bits
module lcb_frame_store (
  input  logic                clk,
  input  logic                rst_n,
  input  lcb_pkg::store_req_t req,
  output lcb_pkg::row_t       rd_data
);
  import lcb_pkg::*;

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  row_t             rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

### rtl/lcb_scan_ctrl.sv
// sequencer: pixel read-modify-write, modulation tick counter and burst generation
// depends on lcb_pkg; drives the frame store and hands bytes to the output register
module lcb_scan_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcb_pkg::in_beat_t   in_beat,
  input  logic                slot_free,
  output logic                emit,
  output lcb_pkg::out_beat_t  emit_beat,
  output lcb_pkg::store_req_t store_req,
  input  lcb_pkg::row_t       rd_data
);
  import lcb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MERGE  = 4'b0010,
    ST_BYTES  = 4'b0100,
    ST_SELECT = 4'b1000
  } state_t;

  localparam logic [COORD_W-1:0] LAYER_TOP  = COORD_W'(CUBE_SIDE - 1);
  localparam logic [COORD_W-1:0] ROW_LAST   = COORD_W'(CUBE_SIDE - 1);
  localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(COLOR_BITS - 1);

  state_t             state_r, state_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] layer_r, layer_nxt;
  logic [CHAN_W-1:0]  chan_r, chan_nxt;
  logic [COORD_W-1:0] pix_x_r, pix_x_nxt;
  logic [PIX_W-1:0]   color_r, color_nxt;
  logic [ADDR_W-1:0]  merge_addr_r, merge_addr_nxt;

  logic              accept;
  logic [TICK_W-1:0] tick_inc;
  logic              tick_hit;
  row_t              row_mrg;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign tick_inc = tick_r + TICK_W'(1);
  assign tick_hit = (tick_inc == (TICK_W'(1) << plane_r));

  always_comb begin
    row_mrg          = rd_data;
    row_mrg[pix_x_r] = color_r;
  end

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    plane_nxt      = plane_r;
    row_nxt        = row_r;
    layer_nxt      = layer_r;
    chan_nxt       = chan_r;
    pix_x_nxt      = pix_x_r;
    color_nxt      = color_r;
    merge_addr_nxt = merge_addr_r;
    store_req      = '0;
    emit           = 1'b0;
    emit_beat      = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_beat.op == OP_PIXEL) begin
            store_req.rd_en = 1'b1;
            store_req.addr  = {in_beat.pos_z, in_beat.pos_y};
            merge_addr_nxt  = {in_beat.pos_z, in_beat.pos_y};
            pix_x_nxt       = in_beat.pos_x;
            color_nxt       = in_beat.pixel_color;
            state_nxt       = ST_MERGE;
          end else if (tick_hit) begin
            // burst starts with the top layer of the scanned row
            store_req.rd_en = 1'b1;
            store_req.addr  = {LAYER_TOP, row_r};
            tick_nxt        = '0;
            layer_nxt       = LAYER_TOP;
            chan_nxt        = CH_BLUE;
            state_nxt       = ST_BYTES;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      ST_MERGE: begin
        store_req.wr_en   = 1'b1;
        store_req.addr    = merge_addr_r;
        store_req.wr_data = row_mrg;
        state_nxt         = ST_IDLE;
      end
      ST_BYTES: begin
        emit                  = slot_free;
        emit_beat.shift_byte  = plane_byte(rd_data, chan_r, plane_r);
        emit_beat.latch_now   = 1'b0;
        emit_beat.plane_shown = plane_r;
        if (slot_free) begin
          if (chan_r == CH_RED) begin
            if (layer_r == '0) begin
              state_nxt = ST_SELECT;
            end else begin
              // next layer is read while the red byte leaves
              store_req.rd_en = 1'b1;
              store_req.addr  = {layer_r - COORD_W'(1), row_r};
              layer_nxt       = layer_r - COORD_W'(1);
              chan_nxt        = CH_BLUE;
            end
          end else begin
            chan_nxt = chan_r - CHAN_W'(1);
          end
        end
      end
      ST_SELECT: begin
        emit                  = slot_free;
        emit_beat.shift_byte  = CUBE_SIDE'(1) << row_r;
        emit_beat.latch_now   = 1'b1;
        emit_beat.plane_shown = plane_r;
        if (slot_free) begin
          row_nxt   = row_r + COORD_W'(1);
          state_nxt = ST_IDLE;
          if (row_r == ROW_LAST) begin
            plane_nxt = (plane_r == PLANE_LAST) ? '0 : plane_r + PLANE_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
      plane_r <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      plane_r <= plane_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    layer_r      <= layer_nxt;
    chan_r       <= chan_nxt;
    pix_x_r      <= pix_x_nxt;
    color_r      <= color_nxt;
    merge_addr_r <= merge_addr_nxt;
  end

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !emit)
    else $error("byte emitted while idle");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("byte emitted into a full output register");

  a_latch_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_beat.latch_now) |=> (state_r == ST_IDLE))
    else $error("burst did not end after the row select byte");

  a_pixel_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_beat.op == OP_PIXEL) |=> (store_req.wr_en && !store_req.rd_en))
    else $error("pixel write not followed by its write-back");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(store_req.rd_en && store_req.wr_en))
    else $error("frame store read and written in the same cycle");

endmodule

### rtl/led_cube_bam_scan_driver.sv
// top level of the led cube bam scan driver: sequencer, frame store and output register
// depends on lcb_pkg, lcb_frame_store and lcb_scan_ctrl
//
//  channel | ports                         | beat
//  --------+-------------------------------+--------------------------------------------
//  in      | in_valid in_ready in_beat     | pixel write or modulation tick
//  out     | out_valid out_ready out_beat  | one shifted byte, latch flag, plane index
//
// pixel write: accepted, then the pixel is merged into its row and the row written back
// tick without burst: only the tick counter steps; a burst tick emits three bytes per layer and the row select,
// one frame store row read per layer overlapped with the red byte of the layer above
// reset clears the counters and the frame store valid bits at once, no clearing sweep
// a stalled out_ready holds the burst; the next item is taken while the last byte waits
module led_cube_bam_scan_driver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcb_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output lcb_pkg::out_beat_t out_beat
);
  import lcb_pkg::*;

  store_req_t store_req;
  row_t       rd_data;
  logic       slot_free;
  logic       emit;
  out_beat_t  emit_beat;

  // output register, parts the sequencer from the consumer
  logic      out_valid_r;
  out_beat_t out_beat_r;

  // slot can take a new byte when empty or when its byte leaves this cycle
  assign slot_free = !out_valid_r || out_ready;

  lcb_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .slot_free (slot_free),
    .emit      (emit),
    .emit_beat (emit_beat),
    .store_req (store_req),
    .rd_data   (rd_data)
  );

  lcb_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat_r <= emit_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

### tb/sv/led_cube_bam_scan_driver_tb.sv
// self-checking testbench for led_cube_bam_scan_driver: pixel writes and modulation ticks in,
// every shifted beat compared with an in-bench model of the bam row scan
// depends on lcb_pkg and the rtl of the block
module led_cube_bam_scan_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcb_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 19;
  localparam int RANDOM_ITEMS = 310;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 200000;
  // window in which neither side ever idles
  localparam int CALM_FROM    = 400;
  localparam int CALM_TO      = 900;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  // model of the block: frame store indexed by layer*side+row, then column
  logic [PIX_W-1:0]   cube_pix [DEPTH][CUBE_SIDE];
  logic [TICK_W-1:0]  mod_ticks;
  logic [PLANE_W-1:0] cur_plane;
  logic [COORD_W-1:0] cur_row;

  in_beat_t  pending_items [$];   // beats still to be offered on the input channel
  out_beat_t burst_bytes [$];     // beats predicted but not yet seen on the output

  int   err_count    = 0;
  int   clk_cycles   = 0;
  logic in_took      = 1'b0;      // input beat accepted at the last rising edge

  led_cube_bam_scan_driver u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  // one bit of one colour channel in the current plane, pixel x of the scanned row into bit x
  function automatic logic [CUBE_SIDE-1:0] column_bits(int z, logic [CHAN_W-1:0] chan);
    logic [CUBE_SIDE-1:0] bits;
    int                   sel;
    sel = int'(chan) * COLOR_BITS + int'(cur_plane);
    for (int x = 0; x < CUBE_SIDE; x++) begin
      bits[x] = cube_pix[z * CUBE_SIDE + int'(cur_row)][x][sel];
    end
    return bits;
  endfunction

  // update the model with one accepted input beat, queueing any burst it sets off
  function automatic void apply_item(in_beat_t b);
    logic [CHAN_W-1:0] chan_order [3];
    out_beat_t         exp_beat;
    chan_order[0] = CH_BLUE;
    chan_order[1] = CH_GREEN;
    chan_order[2] = CH_RED;
    if (b.op == OP_PIXEL) begin
      // a write never touches the tick counter
      cube_pix[int'(b.pos_z) * CUBE_SIDE + int'(b.pos_y)][b.pos_x] = b.pixel_color;
    end else begin
      mod_ticks = mod_ticks + 1'b1;
      // the burst fires once the count reaches the weight of the current plane
      if (mod_ticks == (TICK_W'(1) << cur_plane)) begin
        // top layer first, blue, green then red within each layer
        for (int z = CUBE_SIDE - 1; z >= 0; z--) begin
          for (int c = 0; c < 3; c++) begin
            exp_beat.shift_byte  = column_bits(z, chan_order[c]);
            exp_beat.latch_now   = 1'b0;
            exp_beat.plane_shown = cur_plane;
            burst_bytes.push_back(exp_beat);
          end
        end
        // closing beat: one-hot row select, latch flagged
        exp_beat.shift_byte  = CUBE_SIDE'(1) << cur_row;
        exp_beat.latch_now   = 1'b1;
        exp_beat.plane_shown = cur_plane;
        burst_bytes.push_back(exp_beat);
        mod_ticks = '0;
        cur_row   = cur_row + 1'b1;
        if (cur_row == '0) begin
          cur_plane = (cur_plane == PLANE_W'(COLOR_BITS - 1)) ? '0 : cur_plane + 1'b1;
        end
      end
    end
  endfunction

  // compare one output beat with the oldest prediction, field by field
  function automatic void check_beat(out_beat_t got);
    out_beat_t want;
    if (burst_bytes.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got byte %02h latch %0b plane %0d",
               $time, got.shift_byte, got.latch_now, got.plane_shown);
      err_count++;
    end else begin
      want = burst_bytes.pop_front();
      if (got.shift_byte !== want.shift_byte) begin
        $display("%0t: shift_byte expected %02h got %02h",
                 $time, want.shift_byte, got.shift_byte);
        err_count++;
      end
      if (got.latch_now !== want.latch_now) begin
        $display("%0t: latch_now expected %0b got %0b", $time, want.latch_now, got.latch_now);
        err_count++;
      end
      if (got.plane_shown !== want.plane_shown) begin
        $display("%0t: plane_shown expected %0d got %0d",
                 $time, want.plane_shown, got.plane_shown);
        err_count++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_item(logic op, int x, int y, int z, logic [PIX_W-1:0] colour);
    in_beat_t b;
    b.op          = op;
    b.pos_x       = COORD_W'(x);
    b.pos_y       = COORD_W'(y);
    b.pos_z       = COORD_W'(z);
    b.pixel_color = colour;
    pending_items.push_back(b);
  endfunction

  // mostly fully random colours, now and then all off, all on or a single channel
  function automatic logic [PIX_W-1:0] rand_colour();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // pixel write anywhere, or a tick whose unused fields carry random noise
  function automatic void add_random(logic op);
    add_item(op, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
             rand_colour());
  endfunction

  // random idling on both sides, none inside the calm window
  function automatic bit take_break();
    if (clk_cycles >= CALM_FROM && clk_cycles < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: inputs move on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      // previous beat gone (or none offered): offer the next one or idle
      if (pending_items.size() > 0 && !take_break()) begin
        in_beat  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !take_break();
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    clk_cycles <= clk_cycles + 1;
    if (!rst_n) begin
      in_took   <= 1'b0;
      mod_ticks = '0;
      cur_plane = '0;
      cur_row   = '0;
      for (int a = 0; a < DEPTH; a++) begin
        for (int x = 0; x < CUBE_SIDE; x++) begin
          cube_pix[a][x] = '0;
        end
      end
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        apply_item(in_beat);
      end
      if (out_valid && out_ready) begin
        check_beat(out_beat);
      end
    end
  end

  // watchdog
  initial begin
    while (clk_cycles < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // directed: row 0 gets full-on corner pixels and alternating bit patterns
    add_item(OP_PIXEL, 0, 0, 0, 24'hFFFFFF);
    add_item(OP_PIXEL, 7, 0, 7, 24'hFFFFFF);
    add_item(OP_PIXEL, 3, 0, 4, 24'hAAAAAA);
    add_item(OP_PIXEL, 4, 0, 4, 24'h555555);
    // tick with every unused field high, plane 0 fires on every tick
    add_item(OP_TICK, 7, 7, 7, 24'hFFFFFF);
    add_item(OP_PIXEL, 7, 1, 0, 24'h010101);
    add_item(OP_PIXEL, 0, 1, 7, 24'h000001);
    add_item(OP_TICK, 0, 0, 0, 24'h000000);
    // overwrite of a lit pixel with black, then a red-only neighbour
    add_item(OP_PIXEL, 2, 2, 3, 24'hFFFFFF);
    add_item(OP_PIXEL, 2, 2, 3, 24'h000000);
    add_item(OP_PIXEL, 5, 2, 3, 24'h0000FF);
    add_item(OP_TICK, 7, 7, 7, 24'hFFFFFF);
    // rows 3 to 7, the last one leaves plane 0
    repeat (5) add_item(OP_TICK, 0, 0, 0, 24'h000000);
    // plane 1: first tick gives nothing, the second fires row 0
    add_item(OP_PIXEL, 6, 0, 2, 24'h020202);
    add_item(OP_TICK, 7, 7, 7, 24'hFFFFFF);
    add_item(OP_TICK, 0, 0, 0, 24'h000000);

    // random mix of writes and ticks filling the store as the planes climb
    repeat (RANDOM_ITEMS) add_random($urandom_range(0, 1) ? OP_TICK : OP_PIXEL);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (burst_bytes.size() != 0) @(posedge clk);
    // let any stray beat show itself
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
